>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: item payloads,
// the decoded command that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned DefColumns = 80;
  localparam int unsigned DefRows    = 25;
  localparam int unsigned CharW      = 8;
  localparam int unsigned QueueDepth = 2;  // power of two

  localparam logic [CharW-1:0] NewlineCode = 8'd10;
  localparam logic [CharW-1:0] SpaceCode   = 8'd32;

  localparam logic OpPut  = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CharW-1:0] char_code;
    logic [4:0]       read_row;
    logic [6:0]       read_col;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] cell_char;
    logic [4:0]       cursor_row;
    logic [6:0]       cursor_col;
    logic             scrolled;
  } out_item_t;

  typedef enum logic [1:0] {
    CmdChar,
    CmdNewline,
    CmdRead
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [CharW-1:0] char_code;
    logic [4:0]       read_row;
    logic [6:0]       read_col;
    logic             in_range;
  } cmd_t;

endpackage

>>> rtl/tcw_chan_if.sv
// ----------------------------------------------------------------------------
// tcw_chan_if
// Valid/ready channel carrying one item of type data_t.
// ----------------------------------------------------------------------------
interface tcw_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts items, decodes them into commands and holds them in a short queue
// for the back end.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int unsigned COLUMNS = tcw_pkg::DefColumns,
  parameter int unsigned ROWS    = tcw_pkg::DefRows
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcw_chan_if.sink      in_ch_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output tcw_pkg::cmd_t q_cmd_o
);
  import tcw_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  cmd_t            cmd_new;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  always_comb begin
    cmd_new.char_code = in_ch_i.data.char_code;
    cmd_new.read_row  = in_ch_i.data.read_row;
    cmd_new.read_col  = in_ch_i.data.read_col;
    cmd_new.in_range  = (in_ch_i.data.read_row < ROWS) && (in_ch_i.data.read_col < COLUMNS);
    priority if (in_ch_i.data.op == OpRead) begin
      cmd_new.kind = CmdRead;
    end else if (in_ch_i.data.char_code == NewlineCode) begin
      cmd_new.kind = CmdNewline;
    end else begin
      cmd_new.kind = CmdChar;
    end
  end

  assign in_ch_i.ready = (count_q != CntW'(QueueDepth));
  assign push          = in_ch_i.valid && in_ch_i.ready;
  assign q_valid_o     = (count_q != '0);
  assign pop           = q_valid_o && q_ready_i;
  assign q_cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d    = push ? wr_q + 1'b1 : wr_q;
    rd_d    = pop ? rd_q + 1'b1 : rd_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_new;
    end
  end
endmodule

>>> rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen RAM: cursor update, cell writes,
// cell reads and row fills on scroll. Rows are kept in a ring so a scroll
// only moves the top-row pointer and refills one row.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int unsigned COLUMNS = tcw_pkg::DefColumns,
  parameter int unsigned ROWS    = tcw_pkg::DefRows
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  tcw_pkg::cmd_t q_cmd_i,
  tcw_chan_if.source    out_ch_o
);
  import tcw_pkg::*;

  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned AddrW = $clog2(Cells);

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StRead  = 4'b0100,
    StFill  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [RowW-1:0]  row_q, row_d, top_q, top_d;
  logic [ColW-1:0]  col_q, col_d, fill_q, fill_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [RowW-1:0]  map_row, phys_row;
  logic [ColW-1:0]  map_col;
  logic [RowW:0]    phys_sum;
  logic [AddrW-1:0] map_addr, ram_addr;
  logic [CharW-1:0] ram_wdata, ram_rdata, rd_byte;
  logic             ram_we, load, scr, pop, free, last_col, last_row, adv;

  function automatic logic [RowW-1:0] last_row_top(input logic [RowW-1:0] t);
    return (t == RowW'(ROWS - 1)) ? '0 : t + 1'b1;
  endfunction

  assign free     = !out_valid_q || out_ch_o.ready;
  assign pop      = q_valid_i && free && (state_q == StIdle);
  assign last_col = (col_q == ColW'(COLUMNS - 1));
  assign last_row = (row_q == RowW'(ROWS - 1));

  // logical row/col to RAM address through the top-row ring
  always_comb begin
    map_row = row_q;
    map_col = col_q;
    if (state_q == StFill) begin
      map_row = '0;
      map_col = fill_q;
    end else if (q_cmd_i.kind == CmdRead) begin
      map_row = RowW'(q_cmd_i.read_row);
      map_col = ColW'(q_cmd_i.read_col);
    end
    phys_sum = {1'b0, top_q} + {1'b0, map_row};
    phys_row = (phys_sum >= (RowW+1)'(ROWS)) ? RowW'(phys_sum - (RowW+1)'(ROWS))
                                            : RowW'(phys_sum);
    map_addr = AddrW'(phys_row) * AddrW'(COLUMNS) + AddrW'(map_col);
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    top_d     = top_q;
    clr_d     = clr_q;
    fill_d    = fill_q;
    ram_we    = 1'b0;
    ram_addr  = map_addr;
    ram_wdata = q_cmd_i.char_code;
    load      = 1'b0;
    scr       = 1'b0;
    rd_byte   = '0;
    q_ready_o = 1'b0;
    adv       = 1'b0;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        if (clr_q == AddrW'(Cells - 1)) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      StIdle: begin
        q_ready_o = free;
        if (pop) begin
          unique case (q_cmd_i.kind)
            CmdRead: begin
              if (q_cmd_i.in_range) begin
                state_d = StRead;
              end else begin
                load = 1'b1;
              end
            end
            CmdChar, CmdNewline: begin
              ram_we = (q_cmd_i.kind == CmdChar);
              adv    = (q_cmd_i.kind == CmdNewline) || last_col;
              col_d  = adv ? '0 : col_q + 1'b1;
              if (adv && !last_row) begin
                row_d = row_q + 1'b1;
              end
              if (adv && last_row) begin
                fill_d  = '0;
                state_d = StFill;
              end else begin
                load = 1'b1;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      StRead: begin
        load    = 1'b1;
        rd_byte = ram_rdata;
        state_d = StIdle;
      end
      StFill: begin
        ram_we    = 1'b1;
        ram_wdata = SpaceCode;
        if (fill_q == ColW'(COLUMNS - 1)) begin
          top_d   = last_row_top(top_q);
          load    = 1'b1;
          scr     = 1'b1;
          state_d = StIdle;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_d.cell_char  = rd_byte;
    out_d.cursor_row = 5'(row_d);
    out_d.cursor_col = 7'(col_d);
    out_d.scrolled   = scr;
    out_valid_d      = load ? 1'b1 : (out_ch_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      clr_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      clr_q       <= clr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.data  = out_q;

  tcw_ram #(
    .Width (CharW),
    .Depth (Cells)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );
endmodule

>>> rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode character screen of ROWS x COLUMNS bytes with a write cursor.
// ----------------------------------------------------------------------------
// Put items write a character at the cursor and advance it (newline moves to
// column 0 of the next row, a full row wraps); moving below the last row
// scrolls the screen up one row and fills the bottom row with spaces. Read
// items return one cell. Every item gives one result. Items enter a
// two-entry command queue and are executed one at a time by a back end that
// owns a single-port screen RAM: a put goes from the queue straight to the
// result register, an in-range read first passes the registered RAM read,
// and a scrolling put first refills the recycled row, one space written per
// cycle. After reset the back end clears the screen RAM, one cell per cycle,
// over all ROWS*COLUMNS cells (2000 with defaults); only the queue takes items then.
module text_console_writer_core #(
  parameter int unsigned COLUMNS = tcw_pkg::DefColumns,
  parameter int unsigned ROWS    = tcw_pkg::DefRows
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_chan_if.sink   in_ch_i,
  tcw_chan_if.source out_ch_o
);
  import tcw_pkg::*;

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_cmd_o   (q_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_cmd_i   (q_cmd),
    .out_ch_o  (out_ch_o)
  );

`ifndef SYNTHESIS
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && out_ch_o.data.scrolled |->
      out_ch_o.data.cursor_row == 5'(ROWS - 1) && out_ch_o.data.cursor_col == '0)
    else $error("scroll result with cursor off the bottom row start");

  a_read_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready && q_cmd.kind == CmdRead && q_cmd.in_range |=> !q_ready)
    else $error("queue popped during RAM read");

  a_oob_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready && q_cmd.kind == CmdRead && !q_cmd.in_range |=>
      out_ch_o.valid && out_ch_o.data.cell_char == '0)
    else $error("out-of-range read result missing or nonzero");

  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !q_ready)
    else $error("command taken before screen clear");
`endif
endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_writer_core at its default 80x25 size.
// A directed table covers reset contents, out-of-range reads, extreme bytes,
// newline, last-column wrap and scrolling. A random mix of puts, newlines and
// reads follows. Results are held to table values or a cycle-free predictor.
// Both sides idle in random bursts; one long output stall backs up the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int unsigned RandItems = 1780;
  localparam int unsigned QuietFrom = 1550;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned HoldLen   = 600;

  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tcw_chan_if #(.data_t(in_item_t))  in_ch ();
  tcw_chan_if #(.data_t(out_item_t)) out_ch ();

  text_console_writer_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  logic [CharW-1:0] screen [DefRows][DefColumns];
  int               cur_row;
  int               cur_col;
  out_item_t        pending_results [$];
  stim_row_t        dir_tab [$];

  int  errors;
  int  n_puts;
  int  n_newlines;
  int  n_reads;
  int  n_scrolls;
  int  n_checked;
  bit  quiet;

  always #6 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("tb: errors");
    $finish;
  end

  function automatic out_item_t console_apply(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.op == OpRead) begin
      if (it.read_row < DefRows && it.read_col < DefColumns)
        r.cell_char = screen[it.read_row][it.read_col];
    end else begin
      if (it.char_code == NewlineCode) begin
        cur_row++;
        cur_col = 0;
      end else begin
        screen[cur_row][cur_col] = it.char_code;
        cur_col++;
        if (cur_col >= DefColumns) begin
          cur_row++;
          cur_col = 0;
        end
      end
      if (cur_row >= DefRows) begin
        for (int y = 0; y < DefRows - 1; y++)
          for (int x = 0; x < DefColumns; x++)
            screen[y][x] = screen[y+1][x];
        for (int x = 0; x < DefColumns; x++)
          screen[DefRows-1][x] = SpaceCode;
        cur_row = DefRows - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_row = 5'(cur_row);
    r.cursor_col = 7'(cur_col);
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.op        = OpPut;
    it.char_code = 8'($urandom_range(0, 255));
    it.read_row  = 5'($urandom_range(0, 31));
    it.read_col  = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick >= 42 && pick < 50) begin
      it.char_code = NewlineCode;
    end else if (pick >= 50) begin
      it.op = OpRead;
      if (pick < 88) begin
        it.read_row = 5'($urandom_range(0, DefRows - 1));
        it.read_col = 7'($urandom_range(0, DefColumns - 1));
      end
    end
    return it;
  endfunction

  task automatic deliver(in_item_t it, bit typed, out_item_t exp);
    out_item_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = console_apply(it);
    pending_results.push_back(typed ? exp : predicted);
    if (it.op == OpRead) n_reads++;
    else begin
      n_puts++;
      if (it.char_code == NewlineCode) n_newlines++;
    end
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic compare_field(string nm, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, nm, want, got);
      errors++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %p", $time, got);
      errors++;
    end else begin
      want = pending_results.pop_front();
      compare_field("cell_char", want.cell_char, got.cell_char);
      compare_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
      compare_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
      compare_field("scrolled", 8'(want.scrolled), 8'(got.scrolled));
    end
    if (got.scrolled === 1'b1) n_scrolls++;
    n_checked++;
  endtask

  // output side: random stalls plus one long hold that fills the queue
  initial begin
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.data);
        if (n_checked == HoldAt) hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // input side
  initial begin
    int i;
    int k;
    int n;
    int waited;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    errors      = 0;
    n_puts      = 0;
    n_newlines  = 0;
    n_reads     = 0;
    n_scrolls   = 0;
    n_checked   = 0;
    quiet       = 1'b0;
    cur_row     = 0;
    cur_col     = 0;
    for (int y = 0; y < DefRows; y++)
      for (int x = 0; x < DefColumns; x++)
        screen[y][x] = '0;

    dir_tab.push_back('{'{OpRead, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd24, 7'd79}, 1, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'hff, 5'd25, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd0, 7'd80}, 1, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'hff, 5'd31, 7'd127}, 1, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpPut, 8'h41, 5'd31, 7'd127}, 1, 1'b1, '{8'h00, 5'd0, 7'd1, 1'b0}});
    dir_tab.push_back('{'{OpPut, 8'hff, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd2, 1'b0}});
    dir_tab.push_back('{'{OpPut, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{8'h41, 5'd0, 7'd3, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd0, 7'd1}, 1, 1'b1, '{8'hff, 5'd0, 7'd3, 1'b0}});
    dir_tab.push_back('{'{OpPut, NewlineCode, 5'd0, 7'd0}, 1, 1'b1,
                       '{8'h00, 5'd1, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpPut, NewlineCode, 5'd31, 7'd127}, 1, 1'b1,
                       '{8'h00, 5'd2, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd1, 7'd0}, 1, 1'b1, '{8'h00, 5'd2, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpPut, 8'h09, 5'd0, 7'd0}, 1, 1'b0, '0});
    dir_tab.push_back('{'{OpPut, 8'h0b, 5'd0, 7'd0}, 1, 1'b0, '0});
    dir_tab.push_back('{'{OpPut, NewlineCode, 5'd0, 7'd0}, 22, 1'b0, '0});
    dir_tab.push_back('{'{OpPut, NewlineCode, 5'd0, 7'd0}, 1, 1'b1,
                       '{8'h00, 5'd24, 7'd0, 1'b1}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd24, 7'd5}, 1, 1'b1,
                       '{SpaceCode, 5'd24, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd23, 7'd0}, 1, 1'b0, '0});
    dir_tab.push_back('{'{OpPut, 8'h78, 5'd0, 7'd0}, 79, 1'b0, '0});
    dir_tab.push_back('{'{OpPut, 8'h79, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd24, 7'd0, 1'b1}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd23, 7'd79}, 1, 1'b1, '{8'h79, 5'd24, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd23, 7'd0}, 1, 1'b1, '{8'h78, 5'd24, 7'd0, 1'b0}});
    dir_tab.push_back('{'{OpPut, NewlineCode, 5'd0, 7'd0}, 1, 1'b1,
                       '{8'h00, 5'd24, 7'd0, 1'b1}});
    dir_tab.push_back('{'{OpRead, 8'h00, 5'd22, 7'd79}, 1, 1'b1, '{8'h79, 5'd24, 7'd0, 1'b0}});

    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);

    for (i = 0; i < dir_tab.size(); i++) begin
      for (k = 0; k < dir_tab[i].reps; k++) begin
        deliver(dir_tab[i].item, dir_tab[i].typed && k == dir_tab[i].reps - 1, dir_tab[i].exp);
        idle_gap();
      end
    end

    for (n = 0; n < RandItems; n++) begin
      if (n == QuietFrom) quiet = 1'b1;
      deliver(random_item(), 1'b0, '0);
      idle_gap();
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %p actual none", $time,
               pending_results.size(), pending_results[0]);
      errors++;
    end

    $display("summary: %0d puts (%0d newlines), %0d reads, %0d scrolls, %0d results checked",
             n_puts, n_newlines, n_reads, n_scrolls, n_checked);
    $display("summary: wrap, out-of-range reads and a %0d-cycle output hold exercised", HoldLen);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
